### sv/ab4i_pkg.sv
// ----------------------------------------------------------------------------
// ab4i_pkg
// Shared types, codes and fixed-point helpers of the AB4 integrator.
// ----------------------------------------------------------------------------
package ab4i_pkg;

  localparam int unsigned MaxLengthDefault = 64;
  localparam int unsigned FracBitsDefault  = 16;

  localparam logic [1:0] KIND_STAGE = 2'd0;
  localparam logic [1:0] KIND_STEP  = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  localparam logic [1:0] REG_STEP_SIZE  = 2'd0;
  localparam logic [1:0] REG_VECTOR_LEN = 2'd1;
  localparam logic [1:0] REG_START_TIME = 2'd2;

  localparam logic [31:0] StepSizeReset = 32'h0001_0000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_CALC, ST_MUL, ST_RND, ST_DIV, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_LOAD, OP_RK0, OP_RK1, OP_RK2, OP_RK3, OP_AB1, OP_AB2
  } op_e;

  typedef struct packed {
    logic pk_we;
    logic hist_we;
  } mem_ctl_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh7FFF_FFFF;
    lo = -66'sh8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // v / 2^s rounded to nearest, ties away from zero.
  function automatic logic signed [65:0] rnd_pow2(input logic signed [65:0] v,
                                                 input int unsigned s);
    logic [65:0] mag;
    logic [65:0] r;
    mag = v[65] ? 66'(-v) : 66'(v);
    r = (mag + (66'd1 << (s - 1))) >> s;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

endpackage

### sv/ab4i_mem.sv
// ----------------------------------------------------------------------------
// ab4i_mem
// Element memories: position/k-sum rows and three-deep derivative history.
// ----------------------------------------------------------------------------
module ab4i_mem #(
  parameter int unsigned Depth = ab4i_pkg::MaxLengthDefault,
  parameter int unsigned AW    = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [AW-1:0]       raddr_i,
  input  logic [AW-1:0]       waddr_i,
  input  ab4i_pkg::mem_ctl_t  ctl_i,
  input  logic [63:0]         pk_wdata_i,   // pos[31:0], ksum[63:32]
  input  logic [95:0]         hist_wdata_i, // one[31:0], two[63:32], three[95:64]
  output logic [63:0]         pk_rdata_o,
  output logic [95:0]         hist_rdata_o
);
  import ab4i_pkg::*;

  logic [63:0] pk_mem [Depth];
  logic [95:0] hist_mem [Depth];
  logic [Depth-1:0] hist_vld_q;
  logic [95:0] hist_raw_q;
  logic hist_hit_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.pk_we) begin
      pk_mem[waddr_i] <= pk_wdata_i;
    end
    if (ctl_i.hist_we) begin
      hist_mem[waddr_i] <= hist_wdata_i;
    end
    pk_rdata_o <= pk_mem[raddr_i];
    hist_raw_q <= hist_mem[raddr_i];
  end

  // history valid bits reset: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      hist_hit_q <= 1'b0;
    end else begin
      if (ctl_i.hist_we) begin
        hist_vld_q[waddr_i] <= 1'b1;
      end
      hist_hit_q <= hist_vld_q[raddr_i];
    end
  end

  assign hist_rdata_o = hist_hit_q ? hist_raw_q : '0;

endmodule

### sv/ab4i_div3.sv
// ----------------------------------------------------------------------------
// ab4i_div3
// Serial divide by three, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module ab4i_div3 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  output logic        done_o,
  output logic        busy_o,
  output logic [63:0] quotient_o
);
  import ab4i_pkg::*;

  logic [63:0] quo_q, quo_d;
  logic [1:0]  rem_q, rem_d;
  logic [3:0]  cnt_q;
  logic        busy_q, done_q;

  always_comb begin
    logic [2:0] r3;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < 4; k++) begin
      r3 = {rem_d, quo_d[63]};
      quo_d = {quo_d[62:0], r3 >= 3'd3};
      rem_d = (r3 >= 3'd3) ? 2'(r3 - 3'd3) : r3[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

### sv/adams_bashforth4_integrator_core.sv
// ----------------------------------------------------------------------------
// adams_bashforth4_integrator_core
// Vector ODE integrator, RK4 for three steps then 4-step Adams-Bashforth.
// ----------------------------------------------------------------------------
// Usage: load items (tuser = 0) write state elements and restart the method at
// start_time; each is echoed back. Derivative items (tuser = 1) carry one
// element of f at the last emitted point, in index order; each returns one
// item: the next stage point or, on the final stage and in AB steps, the new
// state element, with the time at which the next derivative is wanted.
// Path: a load item goes through read, calc and done; RK stages 0..2 add the
// multiply and round states; RK stage 3 and AB items also wait on the serial
// divide-by-three unit used for the /6 and /24 scaling.
// One item is worked at a time; s_axis_tready is high only when idle.
// The result sits in an output register; while the receiver stalls the
// finished item holds there and the block waits before its memory write.
// Reset clears the step machine, history valid bits and registers
// (h = 1.0, vector_length 1, start_time 0); no clearing pass is needed.
// ----------------------------------------------------------------------------
module adams_bashforth4_integrator_core
  import ab4i_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = ab4i_pkg::MaxLengthDefault,
  parameter int unsigned FRAC_BITS  = ab4i_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // element[5:0], value[37:6], zero pad
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // point_value[31:0], point_element[37:32],
                                     // point_time[69:38], zero pad
  output logic        m_axis_tlast,  // last_element
  output logic [1:0]  m_axis_tuser,  // point_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ab4i_pkg::*;

  localparam int unsigned AW     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned LimLen = (MAX_LENGTH < 64) ? MAX_LENGTH : 64;

  // configuration
  logic signed [31:0] step_q, start_q;
  logic [6:0] vlen_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StepSizeReset;
      vlen_q  <= 7'd1;
      start_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_STEP_SIZE:  step_q  <= pwdata;
        REG_VECTOR_LEN: vlen_q  <= pwdata[6:0];
        REG_START_TIME: start_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STEP_SIZE:  prdata = step_q;
      REG_VECTOR_LEN: prdata = {25'd0, vlen_q};
      REG_START_TIME: prdata = start_q;
      default:        prdata = '0;
    endcase
  end

  // step machine state
  state_e state_q, state_d;
  op_e op_q;
  logic [1:0] stage_q, steps_q;
  logic [5:0] cnt_q;
  logic signed [31:0] time_q;

  // item registers
  logic [AW-1:0] idx_q;
  logic [5:0] elem_out_q;
  logic signed [31:0] val_q;
  logic wr_ok_q, last_q;
  logic signed [31:0] x_q, ksum_q, pv_q, pt_q, mulb_q;
  logic [95:0] hist_q;
  logic signed [65:0] prod_q;
  logic neg_q;

  logic [6:0] eff;
  always_comb begin
    eff = vlen_q;
    if (eff == 7'd0) eff = 7'd1;
    if (32'(eff) > LimLen) eff = 7'(LimLen);
  end

  // memories and divider
  logic [63:0] pk_rdata;
  logic [95:0] hist_rdata;
  mem_ctl_t mem_ctl;
  logic div_start, div_done, div_busy;
  logic [63:0] div_in, div_q;

  ab4i_mem #(.Depth(MAX_LENGTH), .AW(AW)) u_mem (
    .clk_i, .rst_ni,
    .raddr_i(idx_q), .waddr_i(idx_q), .ctl_i(mem_ctl),
    .pk_wdata_i({ksum_q, (op_q == OP_RK3 || op_q == OP_AB2 || op_q == OP_LOAD)
                         ? pv_q : x_q}),
    .hist_wdata_i(hist_q),
    .pk_rdata_o(pk_rdata), .hist_rdata_o(hist_rdata)
  );

  ab4i_div3 u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_in),
    .done_o(div_done), .busy_o(div_busy), .quotient_o(div_q)
  );

  logic s_fire, out_fire;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = (state_q == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_d = state_q;
    mem_ctl = '0;
    div_start = 1'b0;
    div_in = '0;
    case (state_q)
      ST_IDLE: if (s_fire) state_d = ST_RD;
      ST_RD:   state_d = ST_CALC;
      ST_CALC: begin
        if (op_q == OP_LOAD) state_d = ST_DONE;
        else if (op_q == OP_AB1) state_d = ST_RND;
        else state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_RND;
      ST_RND: begin
        if (op_q == OP_RK3 || op_q == OP_AB1) begin
          div_start = 1'b1;
          if (op_q == OP_RK3) begin
            div_in = 64'(($unsigned(prod_q[65] ? -prod_q : prod_q)
                          + (66'd3 << FRAC_BITS)) >> (FRAC_BITS + 1));
          end else begin
            div_in = 64'(($unsigned(prod_q[65] ? -prod_q : prod_q) + 66'd12) >> 3);
          end
          state_d = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = (op_q == OP_AB1) ? ST_MUL : ST_DONE;
      end
      ST_DONE: begin
        if (out_fire) begin
          mem_ctl.pk_we = (op_q != OP_LOAD) || wr_ok_q;
          mem_ctl.hist_we = (op_q == OP_RK3) ? 1'b0 :
                            (op_q == OP_LOAD) ? 1'b0 : 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    logic signed [31:0] kn;
    logic signed [31:0] r;
    logic signed [65:0] sq;
    case (state_q)
      ST_IDLE: if (s_fire) begin
        val_q <= s_axis_tdata[37:6];
        if (!s_axis_tuser) begin
          op_q <= OP_LOAD;
          idx_q <= AW'(s_axis_tdata[5:0]);
          elem_out_q <= s_axis_tdata[5:0];
          wr_ok_q <= 32'(s_axis_tdata[5:0]) < MAX_LENGTH;
          last_q <= {1'b0, s_axis_tdata[5:0]} == eff - 7'd1;
        end else begin
          wr_ok_q <= 1'b1;
          last_q <= {1'b0, cnt_q} >= eff - 7'd1;
          if (32'(cnt_q) >= MAX_LENGTH) begin
            idx_q <= '0;
            elem_out_q <= '0;
          end else begin
            idx_q <= AW'(cnt_q);
            elem_out_q <= cnt_q;
          end
          if (steps_q == 2'd3) op_q <= OP_AB1;
          else begin
            case (stage_q)
              2'd0: op_q <= OP_RK0;
              2'd1: op_q <= OP_RK1;
              2'd2: op_q <= OP_RK2;
              default: op_q <= OP_RK3;
            endcase
          end
        end
      end
      ST_CALC: begin
        x_q <= pk_rdata[31:0];
        ksum_q <= pk_rdata[63:32];
        hist_q <= hist_rdata;
        if (op_q == OP_LOAD) begin
          pv_q <= val_q;
          pt_q <= start_q;
        end else begin
          if (op_q == OP_RK0 || op_q == OP_RK1) begin
            pt_q <= sat32(66'(time_q) + rnd_pow2(66'(step_q), 1));
          end else begin
            pt_q <= sat32(66'(time_q) + 66'(step_q));
          end
          case (op_q)
            OP_RK0: kn = val_q;
            OP_RK1, OP_RK2: kn = sat32(66'($signed(pk_rdata[63:32])) + 66'(val_q) * 2);
            OP_RK3: kn = sat32(66'($signed(pk_rdata[63:32])) + 66'(val_q));
            default: kn = $signed(pk_rdata[63:32]);
          endcase
          ksum_q <= kn;
          mulb_q <= (op_q == OP_RK3) ? kn : val_q;
          if (op_q == OP_RK0 || op_q == OP_AB1) begin
            hist_q <= {hist_rdata[63:0], val_q};
          end
          prod_q <= 66'(val_q) * 55 - 66'($signed(hist_rdata[31:0])) * 59
                  + 66'($signed(hist_rdata[63:32])) * 37
                  - 66'($signed(hist_rdata[95:64])) * 9;
        end
      end
      ST_MUL: begin
        prod_q <= 66'(step_q * mulb_q);
        if (op_q == OP_AB1) op_q <= OP_AB2;
      end
      ST_RND: begin
        neg_q <= prod_q[65];
        case (op_q)
          OP_RK0, OP_RK1: r = sat32(rnd_pow2(prod_q, FRAC_BITS + 1));
          default:        r = sat32(rnd_pow2(prod_q, FRAC_BITS));
        endcase
        pv_q <= sat32(66'(x_q) + 66'(r));
      end
      ST_DIV: if (div_done) begin
        sq = neg_q ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
        r = sat32(sq);
        if (op_q == OP_AB1) mulb_q <= r;
        else pv_q <= sat32(66'(x_q) + 66'(r));
      end
      default: ;
    endcase
  end

  // step bookkeeping and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      steps_q <= '0;
      cnt_q   <= '0;
      time_q  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (out_fire) begin
        m_axis_tvalid <= 1'b1;
        if (op_q == OP_LOAD) begin
          time_q <= start_q;
          stage_q <= '0;
          cnt_q <= '0;
          steps_q <= '0;
        end else if (last_q) begin
          cnt_q <= '0;
          if (op_q == OP_AB2) begin
            time_q <= pt_q;
          end else if (stage_q == 2'd3) begin
            stage_q <= '0;
            time_q <= pt_q;
            steps_q <= steps_q + 2'd1;
          end else begin
            stage_q <= stage_q + 2'd1;
          end
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      m_axis_tdata <= {2'b00, pt_q, elem_out_q, pv_q};
      m_axis_tlast <= last_q;
      m_axis_tuser <= (op_q == OP_LOAD) ? KIND_LOAD :
                      (op_q == OP_RK3 || op_q == OP_AB2) ? KIND_STEP : KIND_STAGE;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q != 2'd0 |-> steps_q != 2'd3)
    else $error("RK stage active after startup finished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |=> m_axis_tvalid)
    else $error("finished item not presented");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == ST_DIV)
    else $error("divider running outside divide state");

endmodule
